// ===== hdl/aesd_pkg.sv =====
// shared constants, tables and gf functions for the aes-128 decrypt unit
`default_nettype none
package aesd_pkg;

    localparam int NumRounds = 10;
    localparam int RkWords   = 2 * (NumRounds + 1);
    localparam int RkAddrW   = $clog2(RkWords);
    localparam int RndW      = $clog2(NumRounds + 1);

    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul_e(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        return a8 ^ a4 ^ a2;
    endfunction

    function automatic logic [7:0] mul_b(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        return a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] mul_d(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        return a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] mul_9(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        return a8 ^ a;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aesd_key_expand.sv =====
// sequential key expansion, one round key per cycle into the key store
`default_nettype none
module aesd_key_expand (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [127:0]               i_key,
    output logic                            o_busy,
    output logic                            o_wr_en,
    output logic [aesd_pkg::RndW-1:0]       o_wr_round,
    output logic [127:0]                    o_wr_key
);

    logic [127:0]              r_key;
    logic [7:0]                r_rcon;
    logic [aesd_pkg::RndW-1:0] r_round;
    logic                      r_busy;
    logic [127:0]              n_key;
    logic [31:0]               rot;
    logic [31:0]               t;

    always_comb begin
        rot = {r_key[23:0], r_key[31:24]};
        t = {aesd_pkg::SBOX[rot[31:24]], aesd_pkg::SBOX[rot[23:16]],
             aesd_pkg::SBOX[rot[15:8]], aesd_pkg::SBOX[rot[7:0]]} ^ {r_rcon, 24'h0};
        n_key[127:96] = r_key[127:96] ^ t;
        n_key[95:64]  = r_key[95:64] ^ n_key[127:96];
        n_key[63:32]  = r_key[63:32] ^ n_key[95:64];
        n_key[31:0]   = r_key[31:0] ^ n_key[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_rcon  <= 8'h01;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_round <= '0;
            r_rcon  <= 8'h01;
            r_key   <= i_key;
        end else if (r_busy) begin
            r_key   <= n_key;
            r_rcon  <= aesd_pkg::xt(r_rcon);
            r_round <= r_round + 1'b1;
            if (r_round == aesd_pkg::RndW'(aesd_pkg::NumRounds)) r_busy <= 1'b0;
        end
    end

    assign o_busy     = r_busy;
    assign o_wr_en    = r_busy;
    assign o_wr_round = r_round;
    assign o_wr_key   = r_key;

endmodule
`default_nettype wire

// ===== hdl/aesd_round.sv =====
// combinational inverse round: inverse shift rows, inverse sub bytes, key add, inverse mix when i_mix is set
`default_nettype none
module aesd_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_key,
    input  wire logic         i_mix,
    output logic [127:0]      o_state
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = i_state[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = aesd_pkg::INV_SBOX[s[4*((c - r + 4) % 4) + r]]
                             ^ i_key[127 - 8*(4*c + r) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = aesd_pkg::mul_e(t[4*c]) ^ aesd_pkg::mul_b(t[4*c+1])
                     ^ aesd_pkg::mul_d(t[4*c+2]) ^ aesd_pkg::mul_9(t[4*c+3]);
            m[4*c+1] = aesd_pkg::mul_9(t[4*c]) ^ aesd_pkg::mul_e(t[4*c+1])
                     ^ aesd_pkg::mul_b(t[4*c+2]) ^ aesd_pkg::mul_d(t[4*c+3]);
            m[4*c+2] = aesd_pkg::mul_d(t[4*c]) ^ aesd_pkg::mul_9(t[4*c+1])
                     ^ aesd_pkg::mul_e(t[4*c+2]) ^ aesd_pkg::mul_b(t[4*c+3]);
            m[4*c+3] = aesd_pkg::mul_b(t[4*c]) ^ aesd_pkg::mul_d(t[4*c+1])
                     ^ aesd_pkg::mul_9(t[4*c+2]) ^ aesd_pkg::mul_e(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) o_state[127 - 8*i -: 8] = i_mix ? m[i] : t[i];
    end

endmodule
`default_nettype wire

// ===== hdl/aes128_block_decrypt_unit.sv =====
// top level of the aes-128 block decrypt unit
// usage:
//  - key registers are written on i_cfg_we with i_cfg_index 0 (key_high) or 1 (key_low);
//    each write restarts key expansion, during which no word is accepted
//  - after reset the all-zero key is expanded the same way before the first word
//  - s_axis word: tdata[63:0] = cipher_high, tdata[127:64] = cipher_low
//  - m_axis word: tdata[63:0] = plain_high, tdata[127:64] = plain_low
//  - after accept, S_INIT adds the last round key, then in S_RUN one shared
//    round unit runs the ten inverse rounds, one per cycle, and S_DONE
//    moves the block into the output register once that register is free;
//    one key-store read per cycle sets the pace of the rounds
//  - result sits in an output register; when the receiver stalls it holds,
//    and the next word may be accepted but its result waits until taken
//  - a new word is accepted only in S_IDLE, once the last block has left S_DONE
//  - key store has 11 rows of 128 bits, written once per expansion
//  - reset is synchronous active low; it clears the control state and sets r_kx_start
`default_nettype none
module aes128_block_decrypt_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // cipher_high [63:0], cipher_low [127:64]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata   // plain_high [63:0], plain_low [127:64]
);

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_RUN, S_DONE} t_state;

    t_state                    r_state;
    logic [63:0]               r_key_high, r_key_low;
    logic                      r_kx_start;
    logic [127:0]              r_blk;
    logic [aesd_pkg::RndW-1:0] r_rnd;
    logic [127:0]              r_out;
    logic                      r_out_valid;
    logic [127:0]              r_rk;
    logic [127:0]              rk_mem [aesd_pkg::NumRounds + 1];
    logic [aesd_pkg::RndW-1:0] rd_addr;

    logic                      kx_busy, kx_we;
    logic [aesd_pkg::RndW-1:0] kx_round;
    logic [127:0]              kx_key;
    logic [127:0]              rnd_out;
    logic                      mix;

    aesd_key_expand u_kx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_kx_start),
        .i_key({r_key_high, r_key_low}), .o_busy(kx_busy), .o_wr_en(kx_we),
        .o_wr_round(kx_round), .o_wr_key(kx_key)
    );

    // round key memory, one row per round
    always_ff @(posedge i_clk) begin
        if (kx_we) rk_mem[kx_round] <= kx_key;
        r_rk <= rk_mem[rd_addr];
    end

    // last round (round 0) skips inverse mix columns
    assign mix = (r_rnd != '0);
    aesd_round u_rnd (.i_state(r_blk), .i_key(r_rk), .i_mix(mix), .o_state(rnd_out));

    // read address runs one ahead of the round that consumes it
    always_comb begin
        unique case (r_state)
            S_INIT:  rd_addr = r_rnd;
            S_RUN:   rd_addr = (r_rnd == '0) ? aesd_pkg::RndW'(aesd_pkg::NumRounds)
                                             : r_rnd - 1'b1;
            default: rd_addr = aesd_pkg::RndW'(aesd_pkg::NumRounds);
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !kx_busy && !r_kx_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_kx_start  <= 1'b1;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // any key write restarts the expansion
            r_kx_start <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aesd_pkg::CfgKeyHigh: r_key_high <= i_cfg_data;
                    aesd_pkg::CfgKeyLow:  r_key_low  <= i_cfg_data;
                    default: ;
                endcase
            end
            // output valid: set on a new result, held while stalled, cleared when taken
            r_out_valid <= ((r_state == S_DONE) && (!r_out_valid || m_axis_tready))
                           || (r_out_valid && !m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_blk   <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        r_rnd   <= aesd_pkg::RndW'(aesd_pkg::NumRounds - 1);
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    // initial key addition with the last round key
                    r_blk   <= r_blk ^ r_rk;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_blk <= rnd_out;
                    if (r_rnd == '0) r_state <= S_DONE;
                    else             r_rnd <= r_rnd - 1'b1;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out   <= r_blk;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

endmodule
`default_nettype wire
